@@ rtl/csrdp_pkg.sv @@
// ----------------------------------------------------------------------------
// csrdp_pkg
// Shared types, constants and helpers for the csr row dot product block.
// ----------------------------------------------------------------------------
package csrdp_pkg;

    localparam int VEC_DEPTH = 1024;
    localparam int VEC_AW    = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
    localparam int COL_W     = 10;
    localparam int DATA_W    = 32;
    localparam int ACC_W     = 64;

    localparam int QDEPTH    = 4;
    localparam int QAW       = $clog2(QDEPTH);
    localparam int CNT_W     = $clog2(QDEPTH + 1);

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_NZ    = 2'd1,
        KIND_EMPTY = 2'd2
    } kind_t;

    typedef struct packed {
        logic                     is_empty;
        logic                     last;
        logic signed [DATA_W-1:0] mat_value;
        logic signed [DATA_W-1:0] vec_value;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_push_t;

    // column index wrapped into the store depth
    function automatic logic [VEC_AW-1:0] wrap_index(input logic [COL_W-1:0] col);
        logic [COL_W-1:0] r;
        r = col;
        for (int k = COL_W - 1; k >= 0; k--) begin
            if ((longint'(VEC_DEPTH) << k) <= longint'((2 ** COL_W) - 1)) begin
                if (r >= COL_W'(longint'(VEC_DEPTH) << k)) begin
                    r = r - COL_W'(longint'(VEC_DEPTH) << k);
                end
            end
        end
        return VEC_AW'(r);
    endfunction

endpackage

@@ rtl/csrdp_ram.sv @@
// ----------------------------------------------------------------------------
// csrdp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module csrdp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/csrdp_front.sv @@
// ----------------------------------------------------------------------------
// csrdp_front
// Accepts items, writes vector loads, looks up vector entries for nonzeros.
// ----------------------------------------------------------------------------
module csrdp_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_kind,
    input  logic [csrdp_pkg::COL_W-1:0]           s_column,
    input  logic signed [csrdp_pkg::DATA_W-1:0]   s_data_value,
    input  logic                                  s_row_last,
    input  logic [csrdp_pkg::CNT_W-1:0]           q_level,
    output csrdp_pkg::q_push_t                    q_push
);

    logic                                s_fire;
    logic [csrdp_pkg::VEC_AW-1:0]        s_index;
    logic                                s_is_load;
    logic                                s_is_nz;
    logic                                s_is_empty;
    logic [csrdp_pkg::CNT_W:0]           q_use;
    logic [csrdp_pkg::DATA_W-1:0]        ram_rdata;

    logic                                s1_valid_reg;
    logic                                s1_valid_next;
    logic                                s1_empty_reg;
    logic                                s1_last_reg;
    logic signed [csrdp_pkg::DATA_W-1:0] s1_value_reg;

    // reserve a queue slot for the item in the lookup stage
    assign q_use   = {1'b0, q_level} + (csrdp_pkg::CNT_W + 1)'(s1_valid_reg);
    assign s_ready = q_use < (csrdp_pkg::CNT_W + 1)'(csrdp_pkg::QDEPTH);
    assign s_fire  = s_valid && s_ready;
    assign s_index = csrdp_pkg::wrap_index(s_column);

    always_comb begin
        s_is_load  = 1'b0;
        s_is_nz    = 1'b0;
        s_is_empty = 1'b0;
        case (s_kind)
            csrdp_pkg::KIND_LOAD:  s_is_load  = 1'b1;
            csrdp_pkg::KIND_NZ:    s_is_nz    = 1'b1;
            csrdp_pkg::KIND_EMPTY: s_is_empty = 1'b1;
            default: ;
        endcase
    end

    assign s1_valid_next = s_fire && (s_is_nz || s_is_empty);

    csrdp_ram #(
        .WIDTH (csrdp_pkg::DATA_W),
        .DEPTH (csrdp_pkg::VEC_DEPTH)
    ) u_vec_ram (
        .aclk  (aclk),
        .we    (s_fire && s_is_load),
        .waddr (s_index),
        .wdata (s_data_value),
        .raddr (s_index),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_next) begin
            s1_empty_reg <= s_is_empty;
            s1_last_reg  <= s_row_last;
            s1_value_reg <= s_data_value;
        end
    end

    assign q_push.valid           = s1_valid_reg;
    assign q_push.entry.is_empty  = s1_empty_reg;
    assign q_push.entry.last      = s1_last_reg;
    assign q_push.entry.mat_value = s1_value_reg;
    assign q_push.entry.vec_value = ram_rdata;

endmodule

@@ rtl/csrdp_fifo.sv @@
// ----------------------------------------------------------------------------
// csrdp_fifo
// Short queue decoupling the lookup front from the multiply-accumulate back.
// ----------------------------------------------------------------------------
module csrdp_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  csrdp_pkg::q_push_t            q_push,
    input  logic                          q_pop,
    output logic                          q_valid,
    output csrdp_pkg::entry_t             q_entry,
    output logic [csrdp_pkg::CNT_W-1:0]   q_level
);

    csrdp_pkg::entry_t               slots_reg [csrdp_pkg::QDEPTH];
    logic [csrdp_pkg::QAW-1:0]       wr_ptr_reg;
    logic [csrdp_pkg::QAW-1:0]       wr_ptr_next;
    logic [csrdp_pkg::QAW-1:0]       rd_ptr_reg;
    logic [csrdp_pkg::QAW-1:0]       rd_ptr_next;
    logic [csrdp_pkg::CNT_W-1:0]     count_reg;
    logic [csrdp_pkg::CNT_W-1:0]     count_next;
    logic                            do_pop;

    assign q_valid = count_reg != '0;
    assign q_entry = slots_reg[rd_ptr_reg];
    assign q_level = count_reg;
    assign do_pop  = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_push.valid) begin
            wr_ptr_next = (wr_ptr_reg == csrdp_pkg::QAW'(csrdp_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == csrdp_pkg::QAW'(csrdp_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (q_push.valid && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!q_push.valid && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push.valid) begin
            slots_reg[wr_ptr_reg] <= q_push.entry;
        end
    end

endmodule

@@ rtl/csrdp_back.sv @@
// ----------------------------------------------------------------------------
// csrdp_back
// Multiplies queued nonzeros, accumulates with saturation, emits row sums.
// ----------------------------------------------------------------------------
module csrdp_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_valid,
    input  csrdp_pkg::entry_t                    q_entry,
    output logic                                 q_pop,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [csrdp_pkg::ACC_W-1:0]   m_row_sum,
    output logic                                 m_saturated
);

    logic                                mv_reg;
    logic                                mv_next;
    logic                                mul_empty_reg;
    logic                                mul_last_reg;
    logic signed [csrdp_pkg::ACC_W-1:0]  prod_reg;
    logic signed [csrdp_pkg::ACC_W-1:0]  prod_next;

    logic [csrdp_pkg::ACC_W-1:0]         acc_reg;
    logic [csrdp_pkg::ACC_W-1:0]         acc_next;
    logic                                clip_reg;
    logic                                clip_next;

    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [csrdp_pkg::ACC_W-1:0]         out_sum_reg;
    logic [csrdp_pkg::ACC_W-1:0]         out_sum_next;
    logic                                out_sat_reg;
    logic                                out_sat_next;

    logic [csrdp_pkg::ACC_W-1:0]         sum;
    logic [csrdp_pkg::ACC_W-1:0]         sum_sat;
    logic                                ovf;
    logic                                emit;
    logic                                out_free;
    logic                                acc_fire;
    logic                                mul_load;

    assign out_free = !out_valid_reg || m_ready;
    assign emit     = mul_empty_reg || mul_last_reg;
    assign acc_fire = mv_reg && (!emit || out_free);
    assign mul_load = !mv_reg || acc_fire;
    assign q_pop    = mul_load && q_valid;
    assign mv_next  = mul_load ? q_valid : mv_reg;

    assign prod_next = q_entry.mat_value * q_entry.vec_value;

    // saturating add
    assign sum     = acc_reg + prod_reg;
    assign ovf     = (acc_reg[csrdp_pkg::ACC_W-1] == prod_reg[csrdp_pkg::ACC_W-1]) &&
                     (sum[csrdp_pkg::ACC_W-1] != acc_reg[csrdp_pkg::ACC_W-1]);
    assign sum_sat = ovf ? (acc_reg[csrdp_pkg::ACC_W-1] ? csrdp_pkg::ACC_MIN
                                                        : csrdp_pkg::ACC_MAX)
                         : sum;

    always_comb begin
        acc_next       = acc_reg;
        clip_next      = clip_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_sum_next   = out_sum_reg;
        out_sat_next   = out_sat_reg;
        if (acc_fire) begin
            if (mul_empty_reg) begin
                acc_next       = '0;
                clip_next      = 1'b0;
                out_valid_next = 1'b1;
                out_sum_next   = '0;
                out_sat_next   = 1'b0;
            end else if (mul_last_reg) begin
                acc_next       = '0;
                clip_next      = 1'b0;
                out_valid_next = 1'b1;
                out_sum_next   = sum_sat;
                out_sat_next   = clip_reg || ovf;
            end else begin
                acc_next       = sum_sat;
                clip_next      = clip_reg || ovf;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg        <= 1'b0;
            acc_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mv_reg        <= mv_next;
            acc_reg       <= acc_next;
            clip_reg      <= clip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            mul_empty_reg <= q_entry.is_empty;
            mul_last_reg  <= q_entry.last;
            prod_reg      <= prod_next;
        end
        out_sum_reg <= out_sum_next;
        out_sat_reg <= out_sat_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_row_sum   = out_sum_reg;
    assign m_saturated = out_sat_reg;

endmodule

@@ rtl/csr_row_dot_product.sv @@
// ----------------------------------------------------------------------------
// csr_row_dot_product
// Sparse matrix times dense vector, one csr row at a time.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------------
//   s_       | s_valid / s_ready  | s_kind, s_column, s_data_value, s_row_last
//   m_       | m_valid / m_ready  | m_row_sum, m_saturated
//
// one item per cycle sustained while m_ready keeps up; the accumulator update
// closes in a single stage. The row-ending item reaches m_valid via lookup to
// queue, queue to multiply, multiply to accumulate and output
// vector store is a 1024 x 32 ram, contents undefined until loaded
// s_ready drops while the 4-entry queue and the lookup stage hold 4 items
// ----------------------------------------------------------------------------
module csr_row_dot_product (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_kind,
    input  logic [csrdp_pkg::COL_W-1:0]          s_column,
    input  logic signed [csrdp_pkg::DATA_W-1:0]  s_data_value,
    input  logic                                 s_row_last,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [csrdp_pkg::ACC_W-1:0]   m_row_sum,
    output logic                                 m_saturated
);

    csrdp_pkg::q_push_t                q_push;
    csrdp_pkg::entry_t                 q_entry;
    logic                              q_valid;
    logic                              q_pop;
    logic [csrdp_pkg::CNT_W-1:0]       q_level;

    csrdp_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_column     (s_column),
        .s_data_value (s_data_value),
        .s_row_last   (s_row_last),
        .q_level      (q_level),
        .q_push       (q_push)
    );

    csrdp_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_pop   (q_pop),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_level (q_level)
    );

    csrdp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_entry     (q_entry),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_row_sum   (m_row_sum),
        .m_saturated (m_saturated)
    );

    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push.valid |-> (q_level < csrdp_pkg::CNT_W'(csrdp_pkg::QDEPTH)) || q_pop)
        else $error("item pushed into full queue");

    a_queue_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_level <= csrdp_pkg::CNT_W'(csrdp_pkg::QDEPTH))
        else $error("queue level out of range");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for csr_row_dot_product. Vector entries are loaded
// before any nonzero reads them. Row sums are predicted in Q32.32 with
// saturation and compared field by field against the m_ side. Directed rows
// cover the operand extremes, clipping in both directions and the odd item
// kinds. Random row streams follow, with sender gaps, receiver stalls and
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    typedef logic [csrdp_pkg::COL_W-1:0]         col_t;
    typedef logic signed [csrdp_pkg::DATA_W-1:0] data_t;
    typedef logic signed [csrdp_pkg::ACC_W-1:0]  acc_t;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam col_t  COL_MAX_ENTRY = 10'h000;
    localparam col_t  COL_MIN_ENTRY = 10'h3ff;
    localparam col_t  COL_ONE       = 10'h155;
    localparam col_t  COL_NEG_ONE   = 10'h2aa;
    localparam col_t  COL_LOAD_LAST = 10'h200;
    localparam data_t Q_MAX     = 32'sh7fff_ffff;
    localparam data_t Q_MIN     = 32'sh8000_0000;
    localparam data_t Q_ONE     = 32'sh0001_0000;
    localparam data_t Q_NEG_ONE = 32'shffff_0000;

    typedef struct {
        acc_t sum;
        logic clipped;
    } row_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_kind = csrdp_pkg::KIND_LOAD;
    col_t       s_column = '0;
    data_t      s_data_value = '0;
    logic       s_row_last = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    acc_t       m_row_sum;
    logic       m_saturated;

    // row model state
    data_t       vec_copy [csrdp_pkg::VEC_DEPTH];
    acc_t        acc_copy = '0;
    logic        clip_copy = 1'b0;
    row_result_t row_sums_due [$];

    // stimulus bookkeeping
    bit   col_loaded [csrdp_pkg::VEC_DEPTH];
    col_t written_cols [$];
    int   items_sent = 0;
    int   burst_left = 0;
    int   tx_gap_max = 0;
    int   rx_stall_pct = 0;
    int   rx_hold_req = 0;
    int   errors = 0;

    csr_row_dot_product i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_column     (s_column),
        .s_data_value (s_data_value),
        .s_row_last   (s_row_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row_sum    (m_row_sum),
        .m_saturated  (m_saturated)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void compute_row_effect(input logic [1:0] kind,
                                               input col_t col,
                                               input data_t value,
                                               input logic last);
        int unsigned idx;
        acc_t        prod;
        acc_t        total;
        row_result_t res;
        idx = col % csrdp_pkg::VEC_DEPTH;
        case (kind)
            csrdp_pkg::KIND_LOAD: begin
                vec_copy[idx] = value;
                if (!col_loaded[idx]) begin
                    col_loaded[idx] = 1'b1;
                    written_cols.insert(written_cols.size(), col);
                end
            end
            csrdp_pkg::KIND_NZ: begin
                prod = longint'(value) * longint'(vec_copy[idx]);
                total = acc_copy + prod;
                if (acc_copy[csrdp_pkg::ACC_W-1] == prod[csrdp_pkg::ACC_W-1] &&
                    total[csrdp_pkg::ACC_W-1] != acc_copy[csrdp_pkg::ACC_W-1]) begin
                    total = acc_copy[csrdp_pkg::ACC_W-1] ? csrdp_pkg::ACC_MIN
                                                         : csrdp_pkg::ACC_MAX;
                    clip_copy = 1'b1;
                end
                acc_copy = total;
                if (last) begin
                    res.sum = acc_copy;
                    res.clipped = clip_copy;
                    row_sums_due.insert(row_sums_due.size(), res);
                    acc_copy = '0;
                    clip_copy = 1'b0;
                end
            end
            csrdp_pkg::KIND_EMPTY: begin
                res.sum = '0;
                res.clipped = 1'b0;
                row_sums_due.insert(row_sums_due.size(), res);
                acc_copy = '0;
                clip_copy = 1'b0;
            end
            default: ;
        endcase
    endfunction

    function automatic data_t pick_value();
        logic [csrdp_pkg::DATA_W-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 5))
            0, 1: return r;
            2: return r[0] ? Q_MAX : Q_MIN;
            3: return {{14{r[17]}}, r[17:0]};
            4: return r[0] ? Q_ONE : Q_NEG_ONE;
            default: return {{8{r[23]}}, r[23:0]};
        endcase
    endfunction

    function automatic col_t loaded_column();
        return written_cols[$urandom_range(0, written_cols.size() - 1)];
    endfunction

    task automatic send_item(input logic [1:0] kind, input col_t col,
                             input data_t value, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, tx_gap_max);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_column     <= col;
        s_data_value <= value;
        s_row_last   <= last;
        do @(posedge aclk); while (!s_ready);
        compute_row_effect(kind, col, value, last);
        if (kind != KIND_UNUSED) begin
            items_sent++;
        end
    endtask

    task automatic wait_rows_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (row_sums_due.size() != 0);
        burst_left = 0;
    endtask

    task automatic test_basic_rows();
        tx_gap_max = 3;
        rx_stall_pct = 25;
        send_item(csrdp_pkg::KIND_LOAD, COL_MAX_ENTRY, Q_MAX, 1'b0);
        send_item(csrdp_pkg::KIND_LOAD, COL_MIN_ENTRY, Q_MIN, 1'b0);
        send_item(csrdp_pkg::KIND_LOAD, COL_ONE, Q_ONE, 1'b0);
        send_item(csrdp_pkg::KIND_LOAD, COL_NEG_ONE, Q_NEG_ONE, 1'b0);
        send_item(csrdp_pkg::KIND_NZ, COL_ONE, 32'sh0002_0000, 1'b0);
        send_item(csrdp_pkg::KIND_NZ, COL_NEG_ONE, 32'sh0003_0000, 1'b1);
        send_item(csrdp_pkg::KIND_NZ, COL_MIN_ENTRY, 32'sh0, 1'b1);
    endtask

    task automatic test_saturation();
        // min times min twice runs past the positive limit, then keeps going
        send_item(csrdp_pkg::KIND_NZ, COL_MIN_ENTRY, Q_MIN, 1'b0);
        send_item(csrdp_pkg::KIND_NZ, COL_MIN_ENTRY, Q_MIN, 1'b0);
        send_item(csrdp_pkg::KIND_NZ, COL_ONE, 32'sh1, 1'b0);
        send_item(csrdp_pkg::KIND_NZ, COL_NEG_ONE, Q_MAX, 1'b1);
        // negative side
        send_item(csrdp_pkg::KIND_NZ, COL_MAX_ENTRY, Q_MIN, 1'b0);
        send_item(csrdp_pkg::KIND_NZ, COL_MAX_ENTRY, Q_MIN, 1'b0);
        send_item(csrdp_pkg::KIND_NZ, COL_MAX_ENTRY, Q_MIN, 1'b1);
    endtask

    task automatic test_special_items();
        send_item(csrdp_pkg::KIND_EMPTY, 10'h0, 32'sh0, 1'b0);
        // empty row drops a partial row
        send_item(csrdp_pkg::KIND_NZ, COL_ONE, Q_MAX, 1'b0);
        send_item(csrdp_pkg::KIND_EMPTY, 10'h3ff, Q_MIN, 1'b1);
        send_item(csrdp_pkg::KIND_NZ, COL_ONE, Q_ONE, 1'b1);
        // row_last on a load is ignored
        send_item(csrdp_pkg::KIND_LOAD, COL_LOAD_LAST, 32'sh1234_5678, 1'b1);
        send_item(csrdp_pkg::KIND_NZ, COL_LOAD_LAST, Q_ONE, 1'b1);
        // unused kind inside a row changes nothing
        send_item(csrdp_pkg::KIND_NZ, COL_ONE, 32'sh0005_0000, 1'b0);
        send_item(KIND_UNUSED, COL_ONE, Q_MAX, 1'b1);
        send_item(csrdp_pkg::KIND_NZ, COL_NEG_ONE, Q_ONE, 1'b1);
        wait_rows_drained();
    endtask

    task automatic test_backpressure();
        tx_gap_max = 0;
        rx_stall_pct = 0;
        rx_hold_req = 120;
        repeat (24) send_item(csrdp_pkg::KIND_NZ, loaded_column(), pick_value(), 1'b1);
        wait_rows_drained();
    endtask

    task automatic test_random_rows(input int target, input int gap_max, input int stall_pct);
        int pick;
        int len;
        int stop;
        tx_gap_max = gap_max;
        rx_stall_pct = stall_pct;
        stop = items_sent + target;
        while (items_sent < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 15 || written_cols.size() < 8) begin
                len = $urandom_range(1, 6);
                repeat (len) send_item(csrdp_pkg::KIND_LOAD,
                                       col_t'($urandom_range(0, csrdp_pkg::VEC_DEPTH - 1)),
                                       pick_value(), 1'($urandom_range(0, 1)));
            end else if (pick < 75) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    send_item(csrdp_pkg::KIND_NZ, loaded_column(), pick_value(), k == len - 1);
                end
            end else if (pick < 85) begin
                send_item(csrdp_pkg::KIND_EMPTY, col_t'($urandom), $urandom,
                          1'($urandom_range(0, 1)));
            end else if (pick < 93) begin
                len = $urandom_range(1, 4);
                repeat (len) send_item(csrdp_pkg::KIND_NZ, loaded_column(), pick_value(), 1'b0);
                send_item(csrdp_pkg::KIND_EMPTY, col_t'($urandom), $urandom,
                          1'($urandom_range(0, 1)));
            end else begin
                send_item(KIND_UNUSED, col_t'($urandom), $urandom, 1'($urandom_range(0, 1)));
            end
        end
        wait_rows_drained();
    endtask

    initial begin : rx_side
        int hold;
        forever begin
            @(posedge aclk);
            if (rx_hold_req > 0) begin
                hold = rx_hold_req;
                rx_hold_req = 0;
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        row_result_t due;
        if (aresetn && m_valid && m_ready) begin
            if (row_sums_due.size() == 0) begin
                $error("row result with none expected: row_sum %0d saturated %0b",
                       m_row_sum, m_saturated);
                errors++;
            end else begin
                due = row_sums_due.pop_front();
                if (m_row_sum !== due.sum) begin
                    $error("row_sum mismatch: expected %0d, actual %0d", due.sum, m_row_sum);
                    errors++;
                end
                if (m_saturated !== due.clipped) begin
                    $error("saturated mismatch: expected %0b, actual %0b",
                           due.clipped, m_saturated);
                    errors++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_rows();
        test_saturation();
        test_special_items();
        test_backpressure();
        test_random_rows(300, 0, 0);
        test_random_rows(300, 6, 30);
        test_random_rows(300, 3, 70);
        test_random_rows(200, 10, 10);
        s_valid <= 1'b0;
        repeat (12) @(posedge aclk);
        if (errors == 0 && row_sums_due.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/csrdp_pkg.sv
rtl/csrdp_ram.sv
rtl/csrdp_front.sv
rtl/csrdp_fifo.sv
rtl/csrdp_back.sv
rtl/csr_row_dot_product.sv
verif/tb_top.sv
